/* hw/rtl/gta_pkg.sv */
// gta_pkg: shared sizes, codes and the result record of the generation tag allocator
// no dependencies; imported by every module of the block
`default_nettype none

package gta_pkg;

    localparam int SLOT_BITS  = 6;
    localparam int GEN_BITS   = 8;
    localparam int TAG_BITS   = GEN_BITS + SLOT_BITS;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int IN_BITS    = 2 + TAG_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int RES_BITS   = 2 + TAG_BITS + SLOT_BITS;
    localparam int OUT_BYTES  = (RES_BITS + 7) / 8;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [TAG_BITS-1:0]  t_tag;
    typedef logic [GEN_BITS-1:0]  t_gen;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_FREE   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    // packed low to high: status, tag, slot
    typedef struct packed {
        t_slot   slot;
        t_tag    tag;
        t_status status;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/gta_core.sv */
// gta_core: input register, tag and free-stack memories, busy bits and the per-beat update
// depends on gta_pkg
`default_nettype none

module gta_core
    import gta_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [IN_BITS-1:0]   i_in_data,
    output logic                      o_in_ready,
    input  wire logic                 i_res_ready,
    output logic                      o_res_valid,
    output t_result                   o_res
);

    logic [1:0]            r_op;
    t_tag                  r_tag;
    logic                  r_valid;
    t_tag                  r_tag_rd;
    t_tag                  r_stk_rd;
    logic [SLOT_COUNT-1:0] r_busy;
    t_cnt                  r_depth;
    t_cnt                  r_opened;

    t_tag                  mem_tags  [SLOT_COUNT];
    t_tag                  mem_stack [SLOT_COUNT];

    logic    fire;
    logic    accept;
    t_slot   slot_in;
    logic    match;
    t_tag    old_tag;
    t_tag    new_tag;
    t_cnt    n_depth;
    t_cnt    n_opened;
    t_cnt    depth_eff;
    t_cnt    pop_idx;
    logic    tag_we;
    t_slot   tag_waddr;
    t_tag    tag_wdata;
    logic    stk_we;
    t_slot   stk_waddr;
    logic    busy_set;
    logic    busy_clr;
    t_slot   busy_idx;
    t_slot   tag_raddr;
    t_slot   stk_raddr;
    t_result res;

    assign fire       = r_valid && i_res_ready;
    assign o_in_ready = !r_valid || i_res_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign slot_in = r_tag[SLOT_BITS-1:0];
    assign match   = ({1'b0, slot_in} < r_opened) && r_busy[slot_in] && (r_tag_rd == r_tag);
    assign old_tag = r_stk_rd;
    assign new_tag = {t_gen'(old_tag[TAG_BITS-1:SLOT_BITS] + 1'b1), old_tag[SLOT_BITS-1:0]};

    always_comb begin
        res       = '{status: ST_REJECTED, tag: r_tag, slot: slot_in};
        n_depth   = r_depth;
        n_opened  = r_opened;
        tag_we    = 1'b0;
        tag_waddr = slot_in;
        tag_wdata = r_tag;
        stk_we    = 1'b0;
        stk_waddr = r_depth[SLOT_BITS-1:0];
        busy_set  = 1'b0;
        busy_clr  = 1'b0;
        busy_idx  = slot_in;
        case (r_op)
            OP_ALLOC: begin
                if (r_depth != '0) begin
                    // reuse the newest freed tag with the next generation
                    n_depth   = r_depth - 1'b1;
                    tag_we    = 1'b1;
                    tag_waddr = old_tag[SLOT_BITS-1:0];
                    tag_wdata = new_tag;
                    busy_set  = 1'b1;
                    busy_idx  = old_tag[SLOT_BITS-1:0];
                    res       = '{status: ST_OK, tag: new_tag,
                                  slot: old_tag[SLOT_BITS-1:0]};
                end else if (r_opened < t_cnt'(SLOT_COUNT)) begin
                    // open a fresh slot at generation zero
                    n_opened  = r_opened + 1'b1;
                    tag_we    = 1'b1;
                    tag_waddr = r_opened[SLOT_BITS-1:0];
                    tag_wdata = {t_gen'(0), r_opened[SLOT_BITS-1:0]};
                    busy_set  = 1'b1;
                    busy_idx  = r_opened[SLOT_BITS-1:0];
                    res       = '{status: ST_OK,
                                  tag: {t_gen'(0), r_opened[SLOT_BITS-1:0]},
                                  slot: r_opened[SLOT_BITS-1:0]};
                end else begin
                    res = '{status: ST_FULL, tag: '0, slot: '0};
                end
            end
            OP_LOOKUP: begin
                res.status = match ? ST_OK : ST_NOT_FOUND;
            end
            OP_FREE: begin
                if (match) begin
                    busy_clr   = 1'b1;
                    res.status = ST_OK;
                    if (r_depth < t_cnt'(SLOT_COUNT)) begin
                        stk_we  = 1'b1;
                        n_depth = r_depth + 1'b1;
                    end
                end
            end
            default: begin
                res.status = ST_REJECTED;
            end
        endcase
    end

    // read addresses for the next beat see the state this beat leaves behind
    assign depth_eff = fire ? n_depth : r_depth;
    assign pop_idx   = depth_eff - 1'b1;
    assign tag_raddr = i_in_data[2 +: SLOT_BITS];
    assign stk_raddr = pop_idx[SLOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (fire && tag_we) begin
            mem_tags[tag_waddr] <= tag_wdata;
        end
        if (accept) begin
            r_tag_rd <= (fire && tag_we && tag_waddr == tag_raddr) ? tag_wdata
                                                                   : mem_tags[tag_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && stk_we) begin
            mem_stack[stk_waddr] <= r_tag;
        end
        if (accept) begin
            r_stk_rd <= (fire && stk_we && stk_waddr == stk_raddr) ? r_tag
                                                                   : mem_stack[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_data[1:0];
            r_tag <= i_in_data[2 +: TAG_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_busy   <= '0;
            r_depth  <= '0;
            r_opened <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
            if (fire) begin
                r_depth  <= n_depth;
                r_opened <= n_opened;
                if (busy_set) begin
                    r_busy[busy_idx] <= 1'b1;
                end else if (busy_clr) begin
                    r_busy[busy_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_res_valid = r_valid;
    assign o_res       = res;

endmodule

`default_nettype wire

/* hw/rtl/gta_out_reg.sv */
// gta_out_reg: result register between the allocator core and the output stream
// depends on gta_pkg
`default_nettype none

module gta_out_reg
    import gta_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_res_valid,
    input  wire t_result                i_res,
    output logic                        o_res_ready,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_BYTES*8-1:0]      o_data
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_BYTES*8-RES_BITS){1'b0}}, r_res};

endmodule

`default_nettype wire

/* hw/rtl/generation_tag_allocator.sv */
// generation_tag_allocator: top level of the request tag allocator
// depends on gta_pkg, gta_core and gta_out_reg
//
// usage
//   input stream (s_axis): one beat per command; tdata[1:0] is the operation
//   (allocate, look up, free), tdata[15:2] the tag for look up and free
//   output stream (m_axis): exactly one beat per command, in order; tdata[1:0]
//   status, tdata[15:2] allocated or echoed tag, tdata[21:16] slot
//   a tag is generation (high 8 bits) over slot (low 6 bits); reused slots come
//   off a lifo of freed tags with the generation bumped, else a new slot opens
// pipeline and throughput
//   a command sits in the core input register, its result passes through the output
//   register onto m_axis; one command per cycle is sustained while m_axis accepts, each
//   doing one read-modify-write of the tag memory, the free stack top and the busy bits,
//   with the memory reads for the next command forwarded from this command's writes
// reset
//   synchronous active low; clears busy bits, stack depth and the opened-slot
//   count, so the first allocate returns slot 0 at generation 0; the memories
//   are never cleared and only entries already written are ever used
// backpressure
//   a result waiting on m_axis does not block the next command; s_axis_tready
//   drops only when both the core stage and the output register are full
`default_nettype none

module generation_tag_allocator
    import gta_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // command beats
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_BYTES*8-1:0]  s_axis_tdata,   // operation[1:0], tag_in[15:2]
    // result beats
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_BYTES*8-1:0]      m_axis_tdata    // status[1:0], tag_out[15:2],
                                                        // slot_out[21:16], zero pad
);

    logic    core_valid;
    logic    core_ready;
    t_result core_res;

    // allocator state and the per-command update
    gta_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata[IN_BITS-1:0]),
        .o_in_ready  (s_axis_tready),
        .i_res_ready (core_ready),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // result register so a stalled receiver does not stall the core at once
    gta_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (core_valid),
        .i_res       (core_res),
        .o_res_ready (core_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/gta_checker.sv */
// gta_checker: port-level assertions for the generation tag allocator, bound to the top level
// depends on gta_pkg and generation_tag_allocator
`default_nettype none

module gta_checker
    import gta_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_BYTES*8-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_BYTES*8-1:0] m_axis_tdata
);

    // stalled result beat stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // input only stalls when both internal stages are held by the receiver
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // table full reports a zero tag and slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL
        |-> m_axis_tdata[2 +: TAG_BITS] == '0 && m_axis_tdata[2+TAG_BITS +: SLOT_BITS] == '0)
        else $error("table full with nonzero tag");

    // slot field always matches the low bits of the tag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid
        |-> m_axis_tdata[2+TAG_BITS +: SLOT_BITS] == m_axis_tdata[2 +: SLOT_BITS])
        else $error("slot field differs from tag slot bits");

endmodule

bind generation_tag_allocator gta_checker u_gta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
